>>> rtl/rtk_pkg.sv
// types, constants and helpers shared by the rtc tick alarm keeper
`timescale 1ns / 1ps
package rtk_pkg;

	localparam int SUBSEC_BITS = 12;
	localparam int SHIFT_W     = 4;
	localparam int OP_W        = 2;
	localparam int HOUR_W      = 5;
	localparam int MIN_W       = 6;
	localparam int SEC_W       = 6;
	localparam int TICKS_W     = 16;
	localparam int MOD_W       = 11;
	localparam int DAYSEC_W    = 17;
	localparam int TIME_W      = DAYSEC_W + SUBSEC_BITS;
	localparam int ELAPSED_W   = 29;
	localparam int PTICK_W     = SUBSEC_BITS + 1;
	localparam int SPAN_W      = TICKS_W + SUBSEC_BITS;
	localparam int TOTAL_W     = TIME_W + 1;
	localparam int TSEC_W      = TOTAL_W - SUBSEC_BITS;

	localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
	localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);
	localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);
	localparam int                PER_MIN  = 60;
	localparam int                PER_DAY  = 24;

	localparam logic [TIME_W-1:0] DAY_SUBSEC = TIME_W'((24 * 3600) << SUBSEC_BITS);

	localparam logic [SHIFT_W-1:0] TICK_SHIFT_RESET = SHIFT_W'(5);
	localparam logic [SHIFT_W-1:0] FULL_COMPARE     = SHIFT_W'(SUBSEC_BITS);

	// divide by 60 through reciprocal multiplication
	localparam int Q1_W         = 12;
	localparam int Q2_W         = 6;
	localparam int DIV60_SHIFT  = 24;
	localparam int DIV60_MUL    = (1 << DIV60_SHIFT) / PER_MIN + 1;
	localparam int DIV60_MUL_W  = DIV60_SHIFT - 5;
	localparam int PROD1_W      = TSEC_W + DIV60_MUL_W;
	localparam int DIV60S_SHIFT = 18;
	localparam int DIV60S_MUL   = (1 << DIV60S_SHIFT) / PER_MIN + 1;
	localparam int DIV60S_MUL_W = DIV60S_SHIFT - 5;
	localparam int PROD2_W      = Q1_W + DIV60S_MUL_W;

	typedef enum logic [OP_W-1:0] {
		OP_ALARM    = 2'd0,
		OP_IDLE     = 2'd1,
		OP_SET_TIME = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]        operation;
		logic [HOUR_W-1:0]      rtc_hours;
		logic [MIN_W-1:0]       rtc_minutes;
		logic [SEC_W-1:0]       rtc_seconds;
		logic [SUBSEC_BITS-1:0] rtc_subseconds;
		logic [TICKS_W-1:0]     idle_ticks;
	} request_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0]   ticks_elapsed;
		logic                   alarm_armed;
		logic [HOUR_W-1:0]      alarm_hours;
		logic [MIN_W-1:0]       alarm_minutes;
		logic [SEC_W-1:0]       alarm_seconds;
		logic [SUBSEC_BITS-1:0] alarm_subseconds;
		logic [SHIFT_W-1:0]     alarm_compare_bits;
		logic                   alarm_match_time;
	} result_t;

endpackage

>>> rtl/rtk_cfg_if.sv
// configuration write channel carrying the tick shift register value
`timescale 1ns / 1ps
interface rtk_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rtk_pkg::SHIFT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rtk_request_if.sv
// request channel carrying one clock reading and operation per transaction
`timescale 1ns / 1ps
interface rtk_request_if;
	logic              valid;
	logic              ready;
	rtk_pkg::request_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rtk_result_if.sv
// result channel carrying elapsed ticks and the alarm setting per transaction
`timescale 1ns / 1ps
interface rtk_result_if;
	logic             valid;
	logic             ready;
	rtk_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rtc_tick_alarm_keeper.sv
// rtc tick alarm keeper: top level with the full processing pipeline
//
// Usage:
//   cfg writes the tick shift (log2 sub-second counts per os tick); it is
//   always ready, and the user must write it only while no transaction is
//   in flight; the block does not enforce this. request takes one clock
//   reading with an operation: alarm event, idle arm request or set time.
//   result gives exactly one transaction for each request: elapsed ticks
//   and the new alarm setting.
// Pipeline: a request passes the input register, four pipeline stages and
//   then the result register.
// Throughput: one request per cycle while result is taken. The stored last
//   tick time is read and written in the same stage, so back-to-back alarm
//   events see each other. The hour/minute/second split of a full idle alarm
//   uses two reciprocal multipliers on the following stages.
// Reset: the pipeline empties, the last tick time returns to midnight, the
//   tick shift to 5 and the held compare width to the full sub-second field.
// Stall: when result is not taken, its register holds; stages behind fill up
//   bubble by bubble and request drops ready only once all of them are full.
`timescale 1ns / 1ps
module rtc_tick_alarm_keeper (
	input logic           clk,
	input logic           arst_n,
	rtk_cfg_if.sink       cfg,
	rtk_request_if.sink   request,
	rtk_result_if.source  result
);
	import rtk_pkg::*;

	logic [SHIFT_W-1:0]      tick_shift_q;
	logic [TIME_W-1:0]       last_time_q;
	logic [SHIFT_W-1:0]      cbits_held_q;

	logic [SHIFT_W-1:0]      sh;
	logic [PTICK_W-1:0]      per_tick;
	logic [SUBSEC_BITS-1:0]  keep_mask;

	logic                    en1, en2, en3, en4, en5, en_o;
	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;

	request_t                req_s1;

	logic [OP_W-1:0]         op_s2;
	logic [HOUR_W-1:0]       hours_s2;
	logic [MIN_W-1:0]        minutes_s2;
	logic [SEC_W-1:0]        seconds_s2;
	logic [DAYSEC_W-1:0]     secs_s2;
	logic [SUBSEC_BITS-1:0]  up_s2;
	logic [SPAN_W-1:0]       span_s2;
	logic                    small_s2;
	logic                    nz_s2;

	result_t                 res_s3, res_s4, res_s5, out_q;
	logic                    full_s3, full_s4, full_s5;
	logic [TSEC_W-1:0]       tsec_s3, tsec_s4;
	logic [Q1_W-1:0]         q1_s4, q1_s5;
	logic [Q2_W-1:0]         q2_s5;
	logic [SEC_W-1:0]        sec_s5;

	// stage a signals
	logic [HOUR_W-1:0]       h_a;
	logic [MIN_W-1:0]        m_a;
	logic [SEC_W-1:0]        s_a;
	logic [MOD_W-1:0]        mod_a;
	logic [DAYSEC_W-1:0]     secs_a;
	logic [SUBSEC_BITS-1:0]  up_a;
	logic [SPAN_W-1:0]       span_a;
	logic [PTICK_W-1:0]      tps_a;
	logic                    small_a;

	// stage b signals
	logic [TIME_W-1:0]       now_b;
	logic [TIME_W-1:0]       diff_b;
	logic [TIME_W-1:0]       delta_b;
	logic [PTICK_W-1:0]      rem_b;
	logic [SUBSEC_BITS-1:0]  up2_b;
	logic [TOTAL_W-1:0]      total_b;
	logic [SEC_W-1:0]        inc_s_b;
	logic [MIN_W-1:0]        inc_m_b;
	logic [HOUR_W-1:0]       inc_h_b;
	result_t                 res_b;
	logic                    full_b;

	// stage c to e signals
	logic [PROD1_W-1:0]      prod1_c;
	logic [TSEC_W-1:0]       srem_d;
	logic [PROD2_W-1:0]      prod2_d;
	logic [Q1_W-1:0]         mrem_e;
	result_t                 res_e;

	assign sh        = (tick_shift_q > FULL_COMPARE) ? FULL_COMPARE : tick_shift_q;
	assign per_tick  = PTICK_W'(1) << sh;
	assign keep_mask = ~SUBSEC_BITS'(per_tick - PTICK_W'(1));

	assign en_o = !out_v_q || result.ready;
	assign en5  = !v_s5 || en_o;
	assign en4  = !v_s4 || en5;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;

	assign request.ready = en1;
	assign cfg.ready     = 1'b1;
	assign result.valid  = out_v_q;
	assign result.data   = out_q;

	// saturate the reading and form the second of the day
	always_comb begin
		h_a     = (req_s1.rtc_hours > HOUR_MAX) ? HOUR_MAX : req_s1.rtc_hours;
		m_a     = (req_s1.rtc_minutes > MIN_MAX) ? MIN_MAX : req_s1.rtc_minutes;
		s_a     = (req_s1.rtc_seconds > SEC_MAX) ? SEC_MAX : req_s1.rtc_seconds;
		mod_a   = MOD_W'(h_a) * MOD_W'(PER_MIN) + MOD_W'(m_a);
		secs_a  = DAYSEC_W'(mod_a) * DAYSEC_W'(PER_MIN) + DAYSEC_W'(s_a);
		up_a    = ~req_s1.rtc_subseconds & keep_mask;
		span_a  = SPAN_W'(req_s1.idle_ticks) << sh;
		tps_a   = PTICK_W'(1 << SUBSEC_BITS) >> sh;
		small_a = (TICKS_W + 1)'(req_s1.idle_ticks) < (TICKS_W + 1)'(tps_a);
	end

	// elapsed ticks and alarm setting against the stored last tick time
	always_comb begin
		now_b   = {secs_s2, up_s2};
		diff_b  = now_b - last_time_q;
		delta_b = (now_b >= last_time_q) ? diff_b : diff_b + DAY_SUBSEC;
		rem_b   = {1'b0, ~up_s2} - per_tick;
		up2_b   = up_s2 + span_s2[SUBSEC_BITS-1:0];
		total_b = TOTAL_W'(now_b) + TOTAL_W'(span_s2);
		inc_s_b = seconds_s2;
		inc_m_b = minutes_s2;
		inc_h_b = hours_s2;
		if (rem_b[PTICK_W-1]) begin
			if (seconds_s2 >= SEC_MAX) begin
				inc_s_b = '0;
				if (minutes_s2 >= MIN_MAX) begin
					inc_m_b = '0;
					inc_h_b = (hours_s2 >= HOUR_MAX) ? '0 : hours_s2 + HOUR_W'(1);
				end else begin
					inc_m_b = minutes_s2 + MIN_W'(1);
				end
			end else begin
				inc_s_b = seconds_s2 + SEC_W'(1);
			end
		end
		res_b  = '0;
		full_b = 1'b0;
		unique case (op_t'(op_s2))
			OP_ALARM: begin
				res_b.ticks_elapsed      = ELAPSED_W'(delta_b >> sh);
				res_b.alarm_armed        = 1'b1;
				res_b.alarm_hours        = inc_h_b;
				res_b.alarm_minutes      = inc_m_b;
				res_b.alarm_seconds      = inc_s_b;
				res_b.alarm_subseconds   = rem_b[SUBSEC_BITS-1:0];
				res_b.alarm_compare_bits = sh;
			end
			OP_IDLE: begin
				if (nz_s2) begin
					res_b.alarm_armed        = 1'b1;
					res_b.alarm_compare_bits = FULL_COMPARE;
					if (small_s2) begin
						res_b.alarm_hours      = hours_s2;
						res_b.alarm_minutes    = minutes_s2;
						res_b.alarm_seconds    = seconds_s2;
						res_b.alarm_subseconds = ~up2_b;
					end else begin
						res_b.alarm_subseconds = ~total_b[SUBSEC_BITS-1:0];
						res_b.alarm_match_time = 1'b1;
						full_b                 = 1'b1;
					end
				end
			end
			OP_SET_TIME: begin
				res_b.alarm_armed        = 1'b1;
				res_b.alarm_hours        = hours_s2;
				res_b.alarm_minutes      = minutes_s2;
				res_b.alarm_seconds      = seconds_s2;
				res_b.alarm_subseconds   = ~per_tick[SUBSEC_BITS-1:0];
				res_b.alarm_compare_bits = cbits_held_q;
			end
			default: begin
				res_b = '0;
			end
		endcase
	end

	// split total seconds into hours, minutes and seconds
	assign prod1_c = PROD1_W'(tsec_s3) * PROD1_W'(DIV60_MUL);
	assign srem_d  = tsec_s4 - TSEC_W'(q1_s4) * TSEC_W'(PER_MIN);
	assign prod2_d = PROD2_W'(q1_s4) * PROD2_W'(DIV60S_MUL);
	assign mrem_e  = q1_s5 - Q1_W'(q2_s5) * Q1_W'(PER_MIN);

	always_comb begin
		res_e = res_s5;
		if (full_s5) begin
			res_e.alarm_seconds = sec_s5;
			res_e.alarm_minutes = mrem_e[MIN_W-1:0];
			res_e.alarm_hours   = (q2_s5 >= Q2_W'(PER_DAY)) ?
				HOUR_W'(q2_s5 - Q2_W'(PER_DAY)) : HOUR_W'(q2_s5);
		end
	end

	// control state and stored time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_shift_q <= TICK_SHIFT_RESET;
			last_time_q  <= '0;
			cbits_held_q <= FULL_COMPARE;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				tick_shift_q <= cfg.data;
			end
			if (en1) begin
				v_s1 <= request.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en_o) begin
				out_v_q <= v_s5;
			end
			if (v_s2 && en3) begin
				unique case (op_t'(op_s2))
					OP_ALARM: begin
						last_time_q  <= now_b;
						cbits_held_q <= sh;
					end
					OP_IDLE: begin
						if (nz_s2) begin
							cbits_held_q <= FULL_COMPARE;
						end
					end
					OP_SET_TIME: begin
						last_time_q <= {secs_s2, {SUBSEC_BITS{1'b0}}};
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1 <= request.data;
		end
		if (en2) begin
			op_s2      <= req_s1.operation;
			hours_s2   <= h_a;
			minutes_s2 <= m_a;
			seconds_s2 <= s_a;
			secs_s2    <= secs_a;
			up_s2      <= up_a;
			span_s2    <= span_a;
			small_s2   <= small_a;
			nz_s2      <= |req_s1.idle_ticks;
		end
		if (en3) begin
			res_s3  <= res_b;
			full_s3 <= full_b;
			tsec_s3 <= total_b[TOTAL_W-1:SUBSEC_BITS];
		end
		if (en4) begin
			res_s4  <= res_s3;
			full_s4 <= full_s3;
			tsec_s4 <= tsec_s3;
			q1_s4   <= prod1_c[DIV60_SHIFT +: Q1_W];
		end
		if (en5) begin
			res_s5  <= res_s4;
			full_s5 <= full_s4;
			q1_s5   <= q1_s4;
			q2_s5   <= prod2_d[DIV60S_SHIFT +: Q2_W];
			sec_s5  <= srem_d[SEC_W-1:0];
		end
		if (en_o) begin
			out_q <= res_e;
		end
	end

endmodule

>>> tb/tb_rtc_tick_alarm_keeper.sv
// testbench for the rtc tick alarm keeper: scoreboard class, stimulus tasks and result checker
`timescale 1ns / 1ps
module tb_rtc_tick_alarm_keeper;
	import rtk_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SUB_ONE = 1 << SUBSEC_BITS;
	localparam longint unsigned DAY_COUNTS = longint'(24 * 3600) << SUBSEC_BITS;
	localparam int PHASE_LEN = 190;

	class alarm_scoreboard;
		logic [SHIFT_W-1:0] tick_shift;
		longint unsigned last_tick;
		logic [SHIFT_W-1:0] held_bits;
		result_t expected[$];
		int errors;

		function new();
			tick_shift = TICK_SHIFT_RESET;
			last_tick = 0;
			held_bits = FULL_COMPARE;
			errors = 0;
		endfunction

		function void set_shift(logic [SHIFT_W-1:0] v);
			tick_shift = v;
		endfunction

		function longint unsigned day_pos(int unsigned h, int unsigned m, int unsigned s,
				int unsigned up);
			return (longint'((h * 60 + m) * 60 + s) << SUBSEC_BITS) + up;
		endfunction

		function longint unsigned tick_floor(longint unsigned pos, int unsigned sh);
			return pos & ~((64'd1 << sh) - 64'd1);
		endfunction

		task note_request(request_t rq);
			result_t r;
			int unsigned h, m, s, sh, up;
			longint unsigned now, delta, pos, tps;
			int sub;
			r = '0;
			h = (rq.rtc_hours > HOUR_MAX) ? HOUR_MAX : rq.rtc_hours;
			m = (rq.rtc_minutes > MIN_MAX) ? MIN_MAX : rq.rtc_minutes;
			s = (rq.rtc_seconds > SEC_MAX) ? SEC_MAX : rq.rtc_seconds;
			sh = (tick_shift > SUBSEC_BITS) ? SUBSEC_BITS : tick_shift;
			up = (SUB_ONE - 1) - rq.rtc_subseconds;
			case (rq.operation)
				OP_ALARM: begin
					now = tick_floor(day_pos(h, m, s, up), sh);
					delta = (now >= last_tick) ? now - last_tick : now + DAY_COUNTS - last_tick;
					r.ticks_elapsed = ELAPSED_W'(delta >> sh);
					sub = (SUB_ONE - 1) - int'(now % SUB_ONE) - (1 << sh);
					if (sub < 0) begin
						sub += SUB_ONE;
						s++;
						if (s >= 60) begin
							s = 0;
							m++;
							if (m >= 60) begin
								m = 0;
								h++;
								if (h >= 24)
									h = 0;
							end
						end
					end
					r.alarm_armed = 1'b1;
					r.alarm_hours = HOUR_W'(h);
					r.alarm_minutes = MIN_W'(m);
					r.alarm_seconds = SEC_W'(s);
					r.alarm_subseconds = SUBSEC_BITS'(sub);
					r.alarm_compare_bits = SHIFT_W'(sh);
					held_bits = SHIFT_W'(sh);
					last_tick = now;
				end
				OP_IDLE: begin
					if (rq.idle_ticks != 0) begin
						tps = longint'(SUB_ONE) >> sh;
						r.alarm_armed = 1'b1;
						r.alarm_compare_bits = FULL_COMPARE;
						held_bits = FULL_COMPARE;
						if (rq.idle_ticks < tps) begin
							pos = tick_floor(up, sh) + ((longint'(rq.idle_ticks) & (tps - 1)) << sh);
							pos = pos % SUB_ONE;
							r.alarm_subseconds = SUBSEC_BITS'((SUB_ONE - 1) - pos);
							r.alarm_hours = HOUR_W'(h);
							r.alarm_minutes = MIN_W'(m);
							r.alarm_seconds = SEC_W'(s);
						end else begin
							pos = tick_floor(day_pos(h, m, s, up), sh) + (longint'(rq.idle_ticks) << sh);
							r.alarm_subseconds = SUBSEC_BITS'((SUB_ONE - 1) - (pos % SUB_ONE));
							pos = pos >> SUBSEC_BITS;
							r.alarm_seconds = SEC_W'(pos % 60);
							pos = pos / 60;
							r.alarm_minutes = MIN_W'(pos % 60);
							pos = pos / 60;
							r.alarm_hours = HOUR_W'(pos % 24);
							r.alarm_match_time = 1'b1;
						end
					end
				end
				OP_SET_TIME: begin
					last_tick = tick_floor(day_pos(h, m, s, 0), sh);
					r.alarm_armed = 1'b1;
					r.alarm_hours = HOUR_W'(h);
					r.alarm_minutes = MIN_W'(m);
					r.alarm_seconds = SEC_W'(s);
					r.alarm_subseconds = SUBSEC_BITS'((2 * SUB_ONE - 1 - (1 << sh)) % SUB_ONE);
					r.alarm_compare_bits = held_bits;
				end
				default: ;
			endcase
			expected.push_back(r);
		endtask

		task report(string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected.size() == 0) begin
				report("result transaction with nothing pending");
				return;
			end
			want = expected.pop_front();
			if (got.ticks_elapsed !== want.ticks_elapsed)
				report($sformatf("ticks_elapsed got %0d want %0d", got.ticks_elapsed,
					want.ticks_elapsed));
			if (got.alarm_armed !== want.alarm_armed)
				report($sformatf("alarm_armed got %0d want %0d", got.alarm_armed, want.alarm_armed));
			if (got.alarm_hours !== want.alarm_hours)
				report($sformatf("alarm_hours got %0d want %0d", got.alarm_hours, want.alarm_hours));
			if (got.alarm_minutes !== want.alarm_minutes)
				report($sformatf("alarm_minutes got %0d want %0d", got.alarm_minutes,
					want.alarm_minutes));
			if (got.alarm_seconds !== want.alarm_seconds)
				report($sformatf("alarm_seconds got %0d want %0d", got.alarm_seconds,
					want.alarm_seconds));
			if (got.alarm_subseconds !== want.alarm_subseconds)
				report($sformatf("alarm_subseconds got %0d want %0d", got.alarm_subseconds,
					want.alarm_subseconds));
			if (got.alarm_compare_bits !== want.alarm_compare_bits)
				report($sformatf("alarm_compare_bits got %0d want %0d", got.alarm_compare_bits,
					want.alarm_compare_bits));
			if (got.alarm_match_time !== want.alarm_match_time)
				report($sformatf("alarm_match_time got %0d want %0d", got.alarm_match_time,
					want.alarm_match_time));
		endtask
	endclass

	logic clk;
	logic arst_n;
	rtk_cfg_if cfg_bus();
	rtk_request_if request_bus();
	rtk_result_if result_bus();

	alarm_scoreboard sb = new();
	logic [SHIFT_W-1:0] current_shift = TICK_SHIFT_RESET;
	longint unsigned clock_pos = 0;
	int burst_left = 0;
	bit steady = 0;
	logic [SHIFT_W-1:0] shift_plan [9] = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd1, 4'd7, 4'd3, 4'd11,
		4'd14};

	rtc_tick_alarm_keeper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.request(request_bus),
		.result(result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL rtc_tick_alarm_keeper");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
			sb.check_result(result_bus.data);
	end

	initial begin
		int mode, span, beat;
		beat = 0;
		result_bus.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				beat++;
				case (mode)
					0: result_bus.ready <= 1'b1;
					1: result_bus.ready <= ($urandom_range(0, 9) < 7);
					2: result_bus.ready <= ($urandom_range(0, 9) < 3);
					default: result_bus.ready <= (beat % 3 != 0);
				endcase
			end
		end
	end

	task automatic send_request(input request_t rq, input bit keep_valid);
		request_bus.valid <= 1'b1;
		request_bus.data <= rq;
		do @(posedge clk); while (request_bus.ready !== 1'b1);
		sb.note_request(rq);
		if (!keep_valid)
			request_bus.valid <= 1'b0;
	endtask

	task automatic push_item(input request_t rq, input bit last);
		int gap;
		if (burst_left == 0)
			burst_left = $urandom_range(1, 16);
		burst_left--;
		gap = 0;
		if (burst_left == 0 && !steady)
			gap = $urandom_range(1, 8);
		send_request(rq, !last && gap == 0);
		repeat (gap) @(posedge clk);
	endtask

	task automatic write_shift(input logic [SHIFT_W-1:0] v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= v;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		sb.set_shift(v);
		current_shift = v;
	endtask

	task automatic drain();
		while (sb.expected.size() != 0)
			@(posedge clk);
	endtask

	function automatic request_t make(logic [OP_W-1:0] op, int h, int m, int s, int ss,
			int ticks);
		request_t rq;
		rq.operation = op;
		rq.rtc_hours = HOUR_W'(h);
		rq.rtc_minutes = MIN_W'(m);
		rq.rtc_seconds = SEC_W'(s);
		rq.rtc_subseconds = SUBSEC_BITS'(ss);
		rq.idle_ticks = TICKS_W'(ticks);
		return rq;
	endfunction

	function automatic request_t reading(longint unsigned pos);
		int unsigned secs;
		secs = 32'(pos >> SUBSEC_BITS);
		return make(OP_ALARM, secs / 3600, (secs / 60) % 60, secs % 60,
			(SUB_ONE - 1) - int'(pos % SUB_ONE), $urandom_range(0, 65535));
	endfunction

	task automatic directed();
		push_item(make(OP_UNUSED, 31, 63, 63, 4095, 65535), 0);
		push_item(make(OP_ALARM, 0, 0, 0, 4095, 0), 0);
		push_item(make(OP_ALARM, 0, 0, 0, 0, 65535), 0);
		push_item(make(OP_SET_TIME, 23, 59, 59, 0, 65535), 0);
		push_item(make(OP_ALARM, 23, 59, 59, 0, 0), 0);
		push_item(make(OP_ALARM, 0, 0, 0, 4063, 0), 0);
		push_item(make(OP_ALARM, 31, 63, 63, 2048, 0), 0);
		push_item(make(OP_IDLE, 12, 30, 30, 1000, 0), 0);
		push_item(make(OP_SET_TIME, 10, 0, 0, 0, 0), 0);
		push_item(make(OP_IDLE, 10, 0, 0, 4095, 1), 0);
		push_item(make(OP_IDLE, 10, 0, 0, 100, 127), 0);
		push_item(make(OP_IDLE, 10, 0, 0, 100, 128), 0);
		push_item(make(OP_IDLE, 23, 59, 59, 0, 65535), 0);
		push_item(make(OP_SET_TIME, 31, 63, 63, 4095, 65535), 0);
		push_item(make(OP_ALARM, 23, 59, 59, 4095, 0), 0);
		push_item(make(OP_UNUSED, 0, 0, 0, 0, 0), 0);
		push_item(make(OP_IDLE, 31, 63, 63, 0, 32768), 0);
		push_item(make(OP_ALARM, 5, 17, 42, 2730, 21845), 0);
		push_item(make(OP_IDLE, 0, 0, 0, 4095, 65535), 1);
	endtask

	task automatic random_phase(input int count);
		request_t rq;
		int pick, sh, tps;
		sh = (current_shift > SUBSEC_BITS) ? SUBSEC_BITS : current_shift;
		tps = SUB_ONE >> sh;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				clock_pos = longint'($urandom_range(0, 86399)) << SUBSEC_BITS;
				rq = reading(clock_pos);
				rq.operation = OP_SET_TIME;
				rq.rtc_subseconds = SUBSEC_BITS'($urandom);
			end else if (pick < 62) begin
				if ($urandom_range(0, 9) == 0)
					clock_pos += $urandom_range(0, 1 << 22);
				else
					clock_pos += (1 << sh) + $urandom_range(0, (1 << sh) - 1);
				clock_pos = clock_pos % DAY_COUNTS;
				rq = reading(clock_pos);
			end else if (pick < 84) begin
				rq = reading(clock_pos);
				rq.operation = OP_IDLE;
				case ($urandom_range(0, 3))
					0: rq.idle_ticks = TICKS_W'($urandom_range(1, tps));
					1: rq.idle_ticks = TICKS_W'($urandom_range(1, 4096));
					2: rq.idle_ticks = TICKS_W'($urandom_range(0, 65535));
					default: rq.idle_ticks = TICKS_W'($urandom_range(0, 2));
				endcase
			end else if (pick < 90) begin
				rq = request_t'($urandom);
				rq.idle_ticks = TICKS_W'($urandom);
				rq.operation = OP_UNUSED;
			end else begin
				rq = make(OP_W'($urandom_range(0, 3)), $urandom_range(0, 31),
					$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 4095),
					$urandom_range(0, 65535));
			end
			push_item(rq, i == count - 1);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		request_bus.valid <= 1'b0;
		request_bus.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		random_phase(PHASE_LEN / 2);
		drain();
		steady = 1;
		random_phase(PHASE_LEN / 2);
		drain();
		foreach (shift_plan[i]) begin
			write_shift(shift_plan[i]);
			steady = ($urandom_range(0, 3) == 0);
			random_phase(PHASE_LEN);
			drain();
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("PASS rtc_tick_alarm_keeper");
		else
			$display("FAIL rtc_tick_alarm_keeper");
		$finish;
	end

endmodule
